// ===== sv/gmdc_pkg.sv =====
// Shared types and codes for the grid maze carver.
// Used by grid_maze_dfs_carver; no dependencies.
package gmdc_pkg;

  // Input kinds carried on the slave tuser bit.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Result kinds carried on the master tuser field.
  typedef enum logic [2:0] {
    ST_STARTED     = 3'd0,
    ST_CARVED      = 3'd1,
    ST_BACKTRACKED = 3'd2,
    ST_FINISHED    = 3'd3,
    ST_REJECTED    = 3'd4
  } status_t;

  // Wall directions, also the order in which neighbors are gathered.
  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  localparam int GRID_SIZE_RESET = 16;

endpackage

// ===== sv/grid_maze_dfs_carver.sv =====
// Recursive backtracker maze carver: sequencer, visited row memory, cell stack.
// Depends on gmdc_pkg, gmdc_vis_ram and gmdc_stack_ram.
//
// Usage: requests enter on the s_axis channel (tuser = func, tdata = start_x,
// start_y, rand_pick) and each produces exactly one result on m_axis
// (tuser = status, tdata = cell_x, cell_y, direction). The grid side is
// written on the cfg channel, which is always ready; write it only while idle.
// One request is worked on at a time. A step request passes these steps before
// the next request can be accepted: on acceptance the current and upper rows
// of the visited memory are read on its two read ports, S_ROWD reads the lower
// row, S_DEC decides and writes back, S_OUT hands the result to the output
// register. A start request sweeps the visited memory one row per cycle before
// its result is handed over; a rejected start or a step on an empty stack goes
// straight from acceptance to S_OUT. After reset the same sweep runs with
// s_axis_tready low. The top of the stack is kept in a register; a pop refills
// it from the stack memory while the result is being handed over.
// When the receiver stalls, the result waits in the output register and the
// next request is still accepted; its own result then waits until the
// register is free.
module grid_maze_dfs_carver #(
  parameter int MAX_GRID = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,       // grid_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // start_x[4:0], start_y[9:5], rand_pick[17:10]
  input  logic [0:0]  s_axis_tuser,   // func[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // cell_x[4:0], cell_y[9:5], direction[11:10]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);

  localparam int CW       = $clog2(MAX_GRID);
  localparam int SW       = CW + 1;
  localparam int ROWS     = 1 << CW;
  localparam int ROW_W    = 1 << CW;
  localparam int CELLS    = MAX_GRID * MAX_GRID;
  localparam int SA       = $clog2(CELLS);
  localparam int CNT_W    = $clog2(CELLS + 1);
  localparam int SIDE_RST = (gmdc_pkg::GRID_SIZE_RESET > MAX_GRID) ?
                            MAX_GRID : gmdc_pkg::GRID_SIZE_RESET;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROWD,
    S_DEC,
    S_OUT
  } state_t;

  state_t               state;
  logic [CW-1:0]        clr_row;
  logic                 clr_mark;
  logic [CW-1:0]        st_x;
  logic [CW-1:0]        st_y;
  logic [CW-1:0]        top_x;
  logic [CW-1:0]        top_y;
  logic [CNT_W-1:0]     count;
  logic [SW-1:0]        side;
  logic [7:0]           pick_r;
  logic [ROW_W-1:0]     row_c;
  logic [ROW_W-1:0]     row_u;
  logic                 pop_load;
  gmdc_pkg::status_t    res_status;
  logic [4:0]           res_x;
  logic [4:0]           res_y;
  gmdc_pkg::dir_t       res_dir;
  gmdc_pkg::status_t    out_status;
  logic [4:0]           out_x;
  logic [4:0]           out_y;
  gmdc_pkg::dir_t       out_dir;

  // Input fields.
  logic                 in_func;
  logic [4:0]           in_x;
  logic [4:0]           in_y;
  logic [7:0]           in_pick;
  logic                 in_fire;
  logic                 out_free;
  logic                 start_bad;

  // Memory ports.
  logic                 vis_we;
  logic [CW-1:0]        vis_waddr;
  logic [ROW_W-1:0]     vis_wdata;
  logic                 vis_re_a;
  logic [CW-1:0]        vis_raddr_a;
  logic [ROW_W-1:0]     vis_q_a;
  logic                 vis_re_b;
  logic [CW-1:0]        vis_raddr_b;
  logic [ROW_W-1:0]     vis_q_b;
  logic                 stk_we;
  logic [SA-1:0]        stk_waddr;
  logic [2*CW-1:0]      stk_wdata;
  logic                 stk_re;
  logic [SA-1:0]        stk_raddr;
  logic [2*CW-1:0]      stk_q;

  // Step decision.
  logic [3:0]           cand;
  logic [2:0]           k;
  logic [10:0]          prod;
  logic [1:0]           sel;
  logic [2:0]           n;
  gmdc_pkg::dir_t       chosen;
  logic                 do_pop;
  logic                 full;
  logic                 in_x_ok;
  logic                 in_y_ok;
  logic [CW-1:0]        nx;
  logic [CW-1:0]        ny;
  logic [ROW_W-1:0]     new_row;
  logic [CNT_W-1:0]     pop_idx;
  logic [SW-1:0]        cfg_side;

  assign in_func   = s_axis_tuser[0];
  assign in_x      = s_axis_tdata[4:0];
  assign in_y      = s_axis_tdata[9:5];
  assign in_pick   = s_axis_tdata[17:10];
  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign start_bad = (8'(in_x) >= 8'(side)) || (8'(in_y) >= 8'(side));
  assign pop_idx   = count - CNT_W'(2);
  assign full      = (count >= CNT_W'(CELLS));

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {4'b0000, out_dir, out_y, out_x};

  // A grid side of zero acts as one; anything above the memory size is clipped.
  always_comb begin
    if (cfg_data == 6'd0) begin
      cfg_side = SW'(1);
    end else if (7'(cfg_data) > 7'(MAX_GRID)) begin
      cfg_side = SW'(MAX_GRID);
    end else begin
      cfg_side = SW'(cfg_data);
    end
  end

  // Neighbor candidates of the top cell, gathered left, right, up, down.
  // row_c and row_u were read in the previous cycle; the lower row is on port a.
  always_comb begin
    in_x_ok = SW'(top_x) < side;
    in_y_ok = SW'(top_y) < side;
    cand[gmdc_pkg::DIR_LEFT]  = (top_x != '0) && (SW'(top_x) - SW'(1) < side) &&
                                in_y_ok && !row_c[top_x - CW'(1)];
    cand[gmdc_pkg::DIR_RIGHT] = (SW'(top_x) + SW'(1) < side) && in_y_ok &&
                                !row_c[top_x + CW'(1)];
    cand[gmdc_pkg::DIR_UP]    = (top_y != '0) && (SW'(top_y) - SW'(1) < side) &&
                                in_x_ok && !row_u[top_x];
    cand[gmdc_pkg::DIR_DOWN]  = (SW'(top_y) + SW'(1) < side) && in_x_ok &&
                                !vis_q_a[top_x];
    k      = 3'($countones(cand));
    do_pop = (k == 3'd0) || full;
    prod   = 11'(pick_r) * 11'(k);
    sel    = prod[9:8];

    n      = 3'd0;
    chosen = gmdc_pkg::DIR_LEFT;
    for (int i = 0; i < 4; i++) begin
      if (cand[i]) begin
        if (n == 3'(sel)) begin
          chosen = gmdc_pkg::dir_t'(2'(i));
        end
        n = n + 3'd1;
      end
    end

    unique case (chosen)
      gmdc_pkg::DIR_LEFT: begin
        nx      = top_x - CW'(1);
        ny      = top_y;
        new_row = row_c | (ROW_W'(1) << nx);
      end
      gmdc_pkg::DIR_RIGHT: begin
        nx      = top_x + CW'(1);
        ny      = top_y;
        new_row = row_c | (ROW_W'(1) << nx);
      end
      gmdc_pkg::DIR_UP: begin
        nx      = top_x;
        ny      = top_y - CW'(1);
        new_row = row_u | (ROW_W'(1) << nx);
      end
      gmdc_pkg::DIR_DOWN: begin
        nx      = top_x;
        ny      = top_y + CW'(1);
        new_row = vis_q_a | (ROW_W'(1) << nx);
      end
      default: begin
        nx      = top_x;
        ny      = top_y;
        new_row = row_c;
      end
    endcase
  end

  // Memory control. Accesses of one request never overlap those of the next,
  // since a request is only accepted once the previous write-back is done.
  always_comb begin
    vis_we      = 1'b0;
    vis_waddr   = clr_row;
    vis_wdata   = '0;
    vis_re_a    = 1'b0;
    vis_raddr_a = top_y;
    vis_re_b    = 1'b0;
    vis_raddr_b = top_y - CW'(1);
    stk_we      = 1'b0;
    stk_waddr   = count[SA-1:0];
    stk_wdata   = {ny, nx};
    stk_re      = 1'b0;
    stk_raddr   = pop_idx[SA-1:0];
    unique case (state)
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_row;
        if (clr_mark && (clr_row == st_y)) begin
          vis_wdata = ROW_W'(1) << st_x;
        end
      end
      S_IDLE: begin
        if (in_fire && (in_func == gmdc_pkg::FUNC_START) && !start_bad) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = {CW'(in_y), CW'(in_x)};
        end
        if (in_fire && (in_func == gmdc_pkg::FUNC_STEP)) begin
          vis_re_a = 1'b1;
          vis_re_b = 1'b1;
        end
      end
      S_ROWD: begin
        vis_re_a    = 1'b1;
        vis_raddr_a = top_y + CW'(1);
      end
      S_DEC: begin
        if (do_pop) begin
          stk_re = (count > CNT_W'(1));
        end else begin
          vis_we    = 1'b1;
          vis_waddr = ny;
          vis_wdata = new_row;
          stk_we    = 1'b1;
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_row       <= '0;
      clr_mark      <= 1'b0;
      count         <= '0;
      side          <= SW'(SIDE_RST);
      pop_load      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        side <= cfg_side;
      end
      // In S_OUT the valid flag is set below instead.
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_row <= clr_row + CW'(1);
          if (clr_row == CW'(ROWS - 1)) begin
            if (clr_mark) begin
              res_status <= gmdc_pkg::ST_STARTED;
              res_x      <= 5'(st_x);
              res_y      <= 5'(st_y);
              res_dir    <= gmdc_pkg::DIR_LEFT;
              state      <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            pick_r <= in_pick;
            if (in_func == gmdc_pkg::FUNC_START) begin
              if (start_bad) begin
                res_status <= gmdc_pkg::ST_REJECTED;
                res_x      <= in_x;
                res_y      <= in_y;
                res_dir    <= gmdc_pkg::DIR_LEFT;
                state      <= S_OUT;
              end else begin
                st_x     <= CW'(in_x);
                st_y     <= CW'(in_y);
                top_x    <= CW'(in_x);
                top_y    <= CW'(in_y);
                count    <= CNT_W'(1);
                clr_mark <= 1'b1;
                clr_row  <= '0;
                state    <= S_CLEAR;
              end
            end else if (count == '0) begin
              res_status <= gmdc_pkg::ST_FINISHED;
              res_x      <= 5'd0;
              res_y      <= 5'd0;
              res_dir    <= gmdc_pkg::DIR_LEFT;
              state      <= S_OUT;
            end else begin
              state <= S_ROWD;
            end
          end
        end
        S_ROWD: begin
          row_c <= vis_q_a;
          row_u <= vis_q_b;
          state <= S_DEC;
        end
        S_DEC: begin
          res_x <= 5'(top_x);
          res_y <= 5'(top_y);
          if (do_pop) begin
            count      <= count - CNT_W'(1);
            pop_load   <= (count > CNT_W'(1));
            res_status <= gmdc_pkg::ST_BACKTRACKED;
            res_dir    <= gmdc_pkg::DIR_LEFT;
          end else begin
            count      <= count + CNT_W'(1);
            top_x      <= nx;
            top_y      <= ny;
            res_status <= gmdc_pkg::ST_CARVED;
            res_dir    <= chosen;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_status    <= res_status;
            out_x         <= res_x;
            out_y         <= res_y;
            out_dir       <= res_dir;
            // The stack entry below the popped cell becomes the new top.
            if (pop_load) begin
              top_x <= stk_q[CW-1:0];
              top_y <= stk_q[2*CW-1:CW];
            end
            pop_load <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  gmdc_vis_ram #(
    .ROW_W (ROW_W),
    .ROWS  (ROWS)
  ) u_vis (
    .clk     (clk),
    .we      (vis_we),
    .waddr   (vis_waddr),
    .wdata   (vis_wdata),
    .re_a    (vis_re_a),
    .raddr_a (vis_raddr_a),
    .rdata_a (vis_q_a),
    .re_b    (vis_re_b),
    .raddr_b (vis_raddr_b),
    .rdata_b (vis_q_b)
  );

  gmdc_stack_ram #(
    .WIDTH (2 * CW),
    .DEPTH (CELLS)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  // The stack never holds more cells than the largest grid has.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CELLS))
    else $error("stack count beyond capacity");

  // Only one request is in work at a time.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("request accepted while another is in work");

  // Only a carved result reports a wall direction.
  a_dir_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_status != gmdc_pkg::ST_CARVED) |-> out_dir == gmdc_pkg::DIR_LEFT)
    else $error("direction set on a result that carved nothing");

  // A finished result carries no cell.
  a_finished_cell: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_status == gmdc_pkg::ST_FINISHED) |->
    (out_x == 5'd0) && (out_y == 5'd0))
    else $error("finished result with a nonzero cell");

endmodule

// ===== sv/gmdc_vis_ram.sv =====
// Visited bitmap: one row of the grid per word, one write port, two read ports.
// Standalone synchronous memory; no package dependencies.
module gmdc_vis_ram #(
  parameter int ROW_W = 32,
  parameter int ROWS  = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(ROWS)-1:0]  waddr,
  input  logic [ROW_W-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(ROWS)-1:0]  raddr_a,
  output logic [ROW_W-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(ROWS)-1:0]  raddr_b,
  output logic [ROW_W-1:0]         rdata_b
);

  logic [ROW_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== sv/gmdc_stack_ram.sv =====
// Cell stack storage: one write port and one registered read port.
// Standalone synchronous memory; no package dependencies.
module gmdc_stack_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic                      re,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
